[rtl/olcs_pkg.sv]
package olcs_pkg;

  // Datapath defaults
  localparam int FracBits  = 16;
  localparam int RootSteps = 4;
  localparam int IoFrac    = 16;

  // Matrix coefficients carry CoefBits fraction bits in a CoefW-bit signed word
  localparam int CoefBits = 24;
  localparam int CoefW    = 30;

  localparam longint DecOne  = 64'sd10000000000;
  localparam longint DecHalf = 64'sd5000000000;

  localparam int OutW   = 18;
  localparam int OutMax = 131071;
  localparam int OutMin = -131072;

  localparam logic [15:0] ContrastReset = 16'd2294;

  // Round a ten-digit decimal fraction to CoefBits fraction bits
  function automatic logic signed [CoefW-1:0] cq(input longint d);
    longint r;
    r = (d * (64'sd1 << CoefBits) + DecHalf) / DecOne;
    return CoefW'(r);
  endfunction

  localparam logic signed [CoefW-1:0] ToLms [9] = '{
    cq(64'sd4122214708), cq(64'sd5363325363), cq(64'sd514459929),
    cq(64'sd2119034982), cq(64'sd6806995451), cq(64'sd1073969566),
    cq(64'sd883024619),  cq(64'sd2817188376), cq(64'sd6299787005)
  };

  localparam logic signed [CoefW-1:0] ToLab [9] = '{
    cq(64'sd2104542553),   cq(64'sd7936177850),   -cq(64'sd40720468),
    cq(64'sd19779984951),  -cq(64'sd24285922050), cq(64'sd4505937099),
    cq(64'sd259040371),    cq(64'sd7827717662),   -cq(64'sd8086757660)
  };

  localparam logic signed [CoefW-1:0] FromLab [9] = '{
    cq(DecOne), cq(64'sd3963377774),  cq(64'sd2158037573),
    cq(DecOne), -cq(64'sd1055613458), -cq(64'sd638541728),
    cq(DecOne), -cq(64'sd894841775),  -cq(64'sd12914855480)
  };

  localparam logic signed [CoefW-1:0] ToRgb [9] = '{
    cq(64'sd40767416621),  -cq(64'sd33077115913), cq(64'sd2309699292),
    -cq(64'sd12684380046), cq(64'sd26097574011),  -cq(64'sd3413193965),
    -cq(64'sd41960863),    -cq(64'sd7034186147),  cq(64'sd17076147010)
  };

endpackage

[rtl/oklab_lightness_contrast_shift.sv]
// OKLab lightness contrast shift. Takes one linear sRGB pixel per clock and
// returns one result per pixel; most of the pipeline lies in the cube-root
// unit, where each Newton step runs through a squaring stage, a product
// stage, a divider load stage and a restoring divider of FRAC_BITS+2 stages.
// busy is always low: start may be held high every cycle. done marks each
// result for one cycle only; the receiver cannot stall and must take every
// beat as it comes. Write contrast_amount only while no pixel is in flight.
module oklab_lightness_contrast_shift
  import olcs_pkg::*;
#(
  parameter int FRAC_BITS  = FracBits,
  parameter int ROOT_STEPS = RootSteps
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [15:0]            in_red,
  input  logic [15:0]            in_green,
  input  logic [15:0]            in_blue,
  input  logic                   contrast_we,
  input  logic [15:0]            contrast_wdata,
  output logic                   done,
  output logic signed [OutW-1:0] out_red,
  output logic signed [OutW-1:0] out_green,
  output logic signed [OutW-1:0] out_blue,
  output logic                   clipped
);

  localparam int F   = FRAC_BITS;
  localparam int FW  = F + 1;
  localparam int LW  = F + 3;
  localparam int AW  = F + 4;
  localparam int BW  = F + 5;
  localparam int CW  = F + 8;
  localparam int RW  = F + 11;
  localparam int VW  = RW + 16;
  localparam int SQW = 2 * F + 8;
  localparam int PQW = 2 * F + 10;
  localparam logic signed [AW-1:0]  CubeLim  = AW'(64'sd4 << F);
  localparam logic [SQW-1:0]        SqHalf   = SQW'(1) << (F - 1);
  localparam logic signed [PQW-1:0] PrHalf   = PQW'(64'sd1 << (F - 1));
  localparam logic signed [VW-1:0]  SatMax   = VW'(OutMax);
  localparam logic signed [VW-1:0]  SatMin   = VW'(OutMin);

  logic [15:0]   contrast_amount;
  logic [15:0]   q16 [4];
  logic [FW-1:0] qf  [4];

  assign busy = 1'b0;

  // Hold the contrast register
  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_amount <= ContrastReset;
    end else if (contrast_we) begin
      contrast_amount <= contrast_wdata;
    end
  end

  // Bring Q0.16 values to the datapath format
  assign q16[0] = in_red;
  assign q16[1] = in_green;
  assign q16[2] = in_blue;
  assign q16[3] = contrast_amount;

  for (genvar i = 0; i < 4; i++) begin : g_q16
    if (F >= IoFrac) begin : g_up
      assign qf[i] = FW'(q16[i]) << (F - IoFrac);
    end else begin : g_down
      assign qf[i] = FW'((17'(q16[i]) + (17'(1) << (IoFrac - F - 1))) >> (IoFrac - F));
    end
  end

  // Input stage
  logic                 rgb_valid;
  logic signed [F+1:0]  rgb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else begin
      rgb_valid <= start;
    end
    for (int i = 0; i < 3; i++) begin
      rgb[i] <= signed'({1'b0, qf[i]});
    end
  end

  // Linear RGB to LMS
  logic                lms_valid;
  logic signed [LW-1:0] lms [3];

  olcs_mat3 #(.IW(F + 2), .OW(LW), .COEF(ToLms)) u_to_lms (
    .clk(clk), .rst(rst), .in_valid(rgb_valid), .vin(rgb),
    .out_valid(lms_valid), .vout(lms)
  );

  // Cube root per channel
  logic                 root_valid [3];
  logic [F+1:0]         root [3];
  logic signed [F+2:0]  root_s [3];

  for (genvar i = 0; i < 3; i++) begin : g_root
    olcs_cbrt #(.FB(F), .STEPS(ROOT_STEPS)) u_cbrt (
      .clk(clk), .rst(rst), .in_valid(lms_valid), .x(lms[i][F+1:0]),
      .out_valid(root_valid[i]), .y(root[i])
    );
    assign root_s[i] = signed'({1'b0, root[i]});
  end

  // LMS' to Lab
  logic                 lab_valid;
  logic signed [LW-1:0] lab [3];

  olcs_mat3 #(.IW(F + 3), .OW(LW), .COEF(ToLab)) u_to_lab (
    .clk(clk), .rst(rst), .in_valid(root_valid[0]), .vin(root_s),
    .out_valid(lab_valid), .vout(lab)
  );

  // Shift lightness: add the contrast amount when lightness is below it, else subtract it
  logic                 shift_valid;
  logic signed [AW-1:0] lab_sh [3];
  logic signed [AW-1:0] lum;
  logic signed [AW-1:0] camt;

  assign lum  = AW'(lab[0]);
  assign camt = signed'({3'b000, qf[3]});

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_valid <= 1'b0;
    end else begin
      shift_valid <= lab_valid;
    end
    lab_sh[0] <= (lum < camt) ? (lum + camt) : (lum - camt);
    lab_sh[1] <= AW'(lab[1]);
    lab_sh[2] <= AW'(lab[2]);
  end

  // Lab back to LMS'
  logic                 lmsb_valid;
  logic signed [BW-1:0] lmsb [3];

  olcs_mat3 #(.IW(AW), .OW(BW), .COEF(FromLab)) u_from_lab (
    .clk(clk), .rst(rst), .in_valid(shift_valid), .vin(lab_sh),
    .out_valid(lmsb_valid), .vout(lmsb)
  );

  // Cube per channel: clamp and square, round, multiply, round
  logic                  sq_valid, t_valid, pr_valid, cu_valid;
  logic signed [AW-1:0]  vc_n [3];
  logic signed [AW-1:0]  vc_a [3];
  logic signed [AW-1:0]  vc_b [3];
  logic [SQW-1:0]        sq [3];
  logic [SQW-1:0]        sq_rnd [3];
  logic [F+4:0]          tq [3];
  logic signed [PQW-1:0] pr [3];
  logic signed [PQW-1:0] pr_rnd [3];
  logic signed [CW-1:0]  cu [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lmsb[i] > BW'(CubeLim)) begin
        vc_n[i] = CubeLim;
      end else if (lmsb[i] < -BW'(CubeLim)) begin
        vc_n[i] = -CubeLim;
      end else begin
        vc_n[i] = AW'(lmsb[i]);
      end
      sq_rnd[i] = sq[i] + SqHalf;
      pr_rnd[i] = pr[i] + PrHalf - PQW'(signed'({1'b0, pr[i][PQW-1]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      t_valid  <= 1'b0;
      pr_valid <= 1'b0;
      cu_valid <= 1'b0;
    end else begin
      sq_valid <= lmsb_valid;
      t_valid  <= sq_valid;
      pr_valid <= t_valid;
      cu_valid <= pr_valid;
    end
    for (int i = 0; i < 3; i++) begin
      sq[i]   <= SQW'(SQW'(vc_n[i]) * SQW'(vc_n[i]));
      vc_a[i] <= vc_n[i];
      tq[i]   <= sq_rnd[i][2*F+4:F];
      vc_b[i] <= vc_a[i];
      pr[i]   <= PQW'(signed'({1'b0, tq[i]})) * PQW'(vc_b[i]);
      cu[i]   <= CW'(pr_rnd[i] >>> F);
    end
  end

  // LMS to linear RGB
  logic                 rgbo_valid;
  logic signed [RW-1:0] rgbo [3];

  olcs_mat3 #(.IW(CW), .OW(RW), .COEF(ToRgb)) u_to_rgb (
    .clk(clk), .rst(rst), .in_valid(cu_valid), .vin(cu),
    .out_valid(rgbo_valid), .vout(rgbo)
  );

  // Rescale to Q2.16 and saturate
  logic signed [VW-1:0] sv [3];
  logic signed [VW-1:0] sat [3];
  logic [2:0]           hit;

  for (genvar i = 0; i < 3; i++) begin : g_scale
    if (F > IoFrac) begin : g_down
      localparam logic signed [VW-1:0] OHalf = VW'(64'sd1 << (F - IoFrac - 1));
      assign sv[i] = (VW'(rgbo[i]) + OHalf
                      - VW'(signed'({1'b0, rgbo[i][RW-1]}))) >>> (F - IoFrac);
    end else if (F == IoFrac) begin : g_same
      assign sv[i] = VW'(rgbo[i]);
    end else begin : g_up
      assign sv[i] = VW'(rgbo[i]) <<< (IoFrac - F);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sv[i] > SatMax) begin
        sat[i] = SatMax;
        hit[i] = 1'b1;
      end else if (sv[i] < SatMin) begin
        sat[i] = SatMin;
        hit[i] = 1'b1;
      end else begin
        sat[i] = sv[i];
        hit[i] = 1'b0;
      end
    end
  end

  // Drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rgbo_valid;
    end
    out_red   <= OutW'(sat[0]);
    out_green <= OutW'(sat[1]);
    out_blue  <= OutW'(sat[2]);
    clipped   <= |hit;
  end

endmodule

[rtl/olcs_mat3.sv]
module olcs_mat3
  import olcs_pkg::*;
#(
  parameter int IW = 18,
  parameter int OW = 18,
  parameter logic signed [CoefW-1:0] COEF [9] = ToLms
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] vin [3],
  output logic                 out_valid,
  output logic signed [OW-1:0] vout [3]
);

  localparam int PW = IW + CoefW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] Half = SW'(64'sd1 << (CoefBits - 1));

  logic signed [PW-1:0] prod [9];
  logic                 prod_valid;
  logic signed [SW-1:0] sum [3];
  logic signed [SW-1:0] rnd [3];

  // Form the nine products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[3*i+j] <= PW'(vin[j]) * PW'(COEF[3*i+j]);
      end
    end
  end

  // Sum each row and round half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SW'(prod[3*i]) + SW'(prod[3*i+1]) + SW'(prod[3*i+2]);
      rnd[i] = sum[i] + Half - SW'(signed'({1'b0, sum[i][SW-1]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= prod_valid;
    end
    for (int i = 0; i < 3; i++) begin
      vout[i] <= OW'(rnd[i] >>> CoefBits);
    end
  end

endmodule

[rtl/olcs_cbrt.sv]
module olcs_cbrt
  import olcs_pkg::*;
#(
  parameter int FB    = FracBits,
  parameter int STEPS = RootSteps
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [FB+1:0]   x,
  output logic            out_valid,
  output logic [FB+1:0]   y
);

  localparam int XW  = FB + 2;
  localparam int YW  = FB + 2;
  localparam int Y2W = FB + 4;
  localparam int MW  = YW + 1 + Y2W;
  localparam int DW  = 2 * FB + 8;
  localparam int DVW = Y2W + 2;
  localparam int QB  = YW;
  localparam int PW  = $clog2(XW);
  localparam logic [2*YW:0] RoundHalf = (2*YW+1)'(1) << (FB - 1);

  logic [XW-1:0] xs [STEPS+1];
  logic [YW-1:0] ys [STEPS+1];
  logic          vs [STEPS+1];

  logic [PW-1:0] top_bit;
  logic [7:0]    seed_exp;
  logic [7:0]    seed_shift;
  logic [15:0]   seed_mul;

  // Seed from the position of the top set bit, exponent divided by three
  always_comb begin
    top_bit = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) top_bit = PW'(i);
    end
    seed_exp   = 8'(top_bit) + 8'(2 * FB + 2);
    seed_mul   = 16'(seed_exp) * 16'd43;
    seed_shift = 8'(seed_mul >> 7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    xs[0] <= x;
    ys[0] <= YW'(1) << seed_shift;
  end

  // One Newton step per block: y' = (x<<FB + (2y+1)*y2) / (3*y2)
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [XW-1:0]   x1, x2;
    logic [YW-1:0]   y1;
    logic [2*YW-1:0] yy;
    logic            v1, v2;
    logic [2*YW:0]   yy_rnd;
    logic [Y2W-1:0]  y2;
    logic [MW-1:0]   m;
    logic [DVW-1:0]  d3;
    logic [DW-1:0]   rem [QB+1];
    logic [DVW-1:0]  dv  [QB+1];
    logic [QB-1:0]   q   [QB+1];
    logic [XW-1:0]   xc  [QB+1];
    logic            vq  [QB+1];

    // Square the estimate
    always_ff @(posedge clk) begin
      if (rst) begin
        v1 <= 1'b0;
      end else begin
        v1 <= vs[k];
      end
      yy <= ys[k] * ys[k];
      y1 <= ys[k];
      x1 <= xs[k];
    end

    // Round the square back, never let it drop to zero
    always_comb begin
      yy_rnd = ({1'b0, yy} + RoundHalf) >> FB;
      y2     = (yy_rnd == '0) ? Y2W'(1) : yy_rnd[Y2W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v2 <= 1'b0;
      end else begin
        v2 <= v1;
      end
      m  <= MW'({y1, 1'b1}) * MW'(y2);
      d3 <= DVW'(y2) + DVW'({y2, 1'b0});
      x2 <= x1;
    end

    // Load the divider
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[0] <= 1'b0;
      end else begin
        vq[0] <= v2;
      end
      rem[0] <= (DW'(x2) << FB) + DW'(m);
      dv[0]  <= d3;
      q[0]   <= '0;
      xc[0]  <= x2;
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < QB; j++) begin : g_div
      logic [DW-1:0] trial;
      logic          fits;

      always_comb begin
        trial = DW'(dv[j]) << (QB - 1 - j);
        fits  = (rem[j] >= trial);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vq[j+1] <= 1'b0;
        end else begin
          vq[j+1] <= vq[j];
        end
        rem[j+1] <= fits ? (rem[j] - trial) : rem[j];
        q[j+1]   <= {q[j][QB-2:0], fits};
        dv[j+1]  <= dv[j];
        xc[j+1]  <= xc[j];
      end
    end

    assign ys[k+1] = q[QB];
    assign xs[k+1] = xc[QB];
    assign vs[k+1] = vq[QB];
  end

  // Zero input has zero root
  assign y         = (xs[STEPS] == '0) ? '0 : ys[STEPS];
  assign out_valid = vs[STEPS];

endmodule
